@@ design/ppd_pkg.sv @@
// Package: codes, constants, result type and FCS-16 step for the PPP deframer.
package ppd_pkg;

  localparam logic [7:0]  FLAG_BYTE       = 8'h7E;
  localparam logic [7:0]  ESC_BYTE        = 8'h7D;
  localparam logic [7:0]  ESC_XOR         = 8'h20;
  localparam logic [15:0] FCS_INIT        = 16'hFFFF;
  localparam logic [15:0] FCS_GOOD        = 16'hF0B8;
  localparam logic [15:0] FCS_POLY        = 16'h8408;
  localparam logic [15:0] DELAY_DEPTH     = 16'd2;
  localparam logic [15:0] SHORT_FRAME_MAX = 16'd2;
  localparam logic [15:0] MAX_LEN_RST     = 16'd1024;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_DATA     = 3'd1;
  localparam logic [2:0] EV_GOOD     = 3'd2;
  localparam logic [2:0] EV_BAD      = 3'd3;
  localparam logic [2:0] EV_OVERFLOW = 3'd4;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] data_byte;
  } step_res_t;

  // One byte of the reflected CRC, bit by bit, LSB first.
  function automatic logic [15:0] fcs16_update(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] v;
    v = fcs ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (v[0]) begin
        v = (v >> 1) ^ FCS_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

@@ design/ppd_if.sv @@
// Interfaces: received byte channel and result channel of the PPP deframer.
interface ppd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ppd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] data_byte;

  modport source (output valid, output event_res, output data_byte, input ready);
  modport sink   (input valid, input event_res, input data_byte, output ready);
endinterface

@@ design/ppd_in_reg.sv @@
// Input register: holds one received byte until the core takes it.
module ppd_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_ready,
  input  logic       adv,
  output logic       hold_vld,
  output logic [7:0] hold_byte
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;

  // refill whenever the held byte is empty or moves on this cycle
  assign in_ready = !vld_r || adv;
  assign vld_nxt  = in_ready ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

  assign hold_vld  = vld_r;
  assign hold_byte = byte_r;

endmodule

@@ design/ppd_core.sv @@
// Deframer core: escape, length limit, FCS-16 and two-byte delay line.
module ppd_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [15:0]            cfg_wdata,
  input  logic                   fire,
  input  logic [7:0]             in_byte,
  output ppd_pkg::step_res_t     res
);

  logic        esc_r,  esc_nxt;
  logic [15:0] pos_r,  pos_nxt;
  logic [15:0] fcs_r,  fcs_nxt;
  logic [7:0]  dly0_r, dly0_nxt;
  logic [7:0]  dly1_r, dly1_nxt;
  logic [15:0] max_len_r;

  always_comb begin
    logic [7:0] stored;
    stored   = in_byte;
    esc_nxt  = esc_r;
    pos_nxt  = pos_r;
    fcs_nxt  = fcs_r;
    dly0_nxt = dly0_r;
    dly1_nxt = dly1_r;
    res      = '0;
    if (in_byte == ppd_pkg::FLAG_BYTE) begin
      // short frames leave everything as it is
      if (pos_r > ppd_pkg::SHORT_FRAME_MAX) begin
        res.event_res = (fcs_r == ppd_pkg::FCS_GOOD) ? ppd_pkg::EV_GOOD : ppd_pkg::EV_BAD;
        esc_nxt = 1'b0;
        pos_nxt = '0;
        fcs_nxt = ppd_pkg::FCS_INIT;
      end
    end else if (pos_r >= max_len_r) begin
      res.event_res = ppd_pkg::EV_OVERFLOW;
    end else if (!esc_r && in_byte == ppd_pkg::ESC_BYTE) begin
      esc_nxt = 1'b1;
    end else begin
      if (esc_r) begin
        stored = in_byte ^ ppd_pkg::ESC_XOR;
      end
      esc_nxt = 1'b0;
      fcs_nxt = ppd_pkg::fcs16_update(fcs_r, stored);
      if (pos_r >= ppd_pkg::DELAY_DEPTH) begin
        res.event_res = ppd_pkg::EV_DATA;
        res.data_byte = dly0_r;
      end
      dly0_nxt = dly1_r;
      dly1_nxt = stored;
      pos_nxt  = pos_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
      pos_r <= '0;
      fcs_r <= ppd_pkg::FCS_INIT;
    end else if (fire) begin
      esc_r <= esc_nxt;
      pos_r <= pos_nxt;
      fcs_r <= fcs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      dly0_r <= dly0_nxt;
      dly1_r <= dly1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= ppd_pkg::MAX_LEN_RST;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_byte == ppd_pkg::FLAG_BYTE && pos_r > ppd_pkg::SHORT_FRAME_MAX
    |=> pos_r == '0 && !esc_r && fcs_r == ppd_pkg::FCS_INIT)
    else $error("frame close did not clear frame state");

  a_data_needs_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.event_res == ppd_pkg::EV_DATA |-> pos_r >= ppd_pkg::DELAY_DEPTH)
    else $error("data released before delay line filled");

  a_overflow_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.event_res == ppd_pkg::EV_OVERFLOW && !cfg_we
    |=> $stable(pos_r) && $stable(esc_r) && $stable(fcs_r))
    else $error("overflowed byte altered frame state");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(pos_r) && $stable(fcs_r))
    else $error("frame state moved without a byte");

endmodule

@@ design/ppd_out_reg.sv @@
// Result register: holds one result until the sink takes it.
module ppd_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  ppd_pkg::step_res_t res,
  output logic               adv,
  output logic               out_valid,
  input  logic               out_ready,
  output ppd_pkg::step_res_t out_res
);

  logic               vld_r;
  logic               vld_nxt;
  ppd_pkg::step_res_t res_r;

  assign adv     = !vld_r || out_ready;
  assign vld_nxt = adv ? fire : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

@@ design/ppp_byte_destuff_deframer.sv @@
// Top level: PPP async HDLC-like byte destuffer and deframer with FCS-16 check.
// Every received byte transfer gives exactly one result transfer, in order; event
// none (0) is sent too, for escape bytes, flags on short frames and the first two
// stored bytes of a frame. A flag closes a frame only when more than two
// destuffed bytes are stored, and the result is frame end good (2) or bad (3)
// from a running FCS-16 (reflected 0x8408, start 0xFFFF, good residue 0xF0B8)
// taken over every stored byte. Data bytes (1) come out two stored bytes late, so
// the two FCS bytes never appear as data. Bytes past the length limit set by
// cfg_wdata are dropped with event 4. Rate: one byte per clock sustained while
// the sink is ready. The byte is held in the input register, and the escape,
// FCS-16 byte step and length compare between the input register and the result
// register load the result into the result register. While a finished result
// waits, the input register still takes one new byte. Write cfg_wdata with cfg_we
// only while no transfer is in flight; the limit resets to 1024.
module ppp_byte_destuff_deframer (
  input  logic        clk,
  input  logic        rst_n,
  ppd_in_if.sink      in_chan,
  ppd_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic               adv;
  logic               hold_vld;
  logic [7:0]         hold_byte;
  logic               fire;
  ppd_pkg::step_res_t res;
  ppd_pkg::step_res_t out_res;

  // hold the received byte
  ppd_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_byte   (in_chan.rx_byte),
    .in_ready  (in_chan.ready),
    .adv       (adv),
    .hold_vld  (hold_vld),
    .hold_byte (hold_byte)
  );

  // advance the frame state once per held byte the result stage can take
  assign fire = hold_vld && adv;

  ppd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .in_byte   (hold_byte),
    .res       (res)
  );

  ppd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res       (res),
    .adv       (adv),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res)
  );

  assign out_chan.event_res = out_res.event_res;
  assign out_chan.data_byte = out_res.data_byte;

endmodule
